// ===== hdl/rhc_pkg.sv =====
// Shared constants for the RGB/HSV pixel converter.
// No dependencies; every other file in hdl refers to it by scoped names.
`default_nettype none
package rhc_pkg;
   localparam int unsigned CHAN_BITS = 12;

   typedef enum logic {
      KIND_TO_HSV = 1'b0,
      KIND_TO_RGB = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;
endpackage
`default_nettype wire

// ===== hdl/rgb_hsv_convert.sv =====
// An accepted req beat passes through rhc_prep, the rhc_div stages and rhc_post, registered in each, to its rsp beat.
// Throughput: one pixel per cycle while the output is not stalled; the pipeline has one divider stage per quotient bit.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears every valid bit; payload registers are not reset.
// Depends on rhc_pkg, rhc_prep, rhc_div and rhc_post.
`default_nettype none
module rgb_hsv_convert #(
   parameter int unsigned CHANNEL_BITS = rhc_pkg::CHAN_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_kind,
   input  wire logic [CHANNEL_BITS-1:0] req_chan_first,
   input  wire logic [CHANNEL_BITS-1:0] req_chan_second,
   input  wire logic [CHANNEL_BITS-1:0] req_chan_third,
   input  wire logic [CHANNEL_BITS-1:0] req_alpha_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [CHANNEL_BITS-1:0]      rsp_out_first,
   output logic [CHANNEL_BITS-1:0]      rsp_out_second,
   output logic [CHANNEL_BITS-1:0]      rsp_out_third,
   output logic [CHANNEL_BITS-1:0]      rsp_alpha_out
);
   localparam int unsigned B  = CHANNEL_BITS;
   localparam int unsigned DW = B + 3;
   localparam int unsigned SW = 1 + B + B + 3 + B;

   logic            en;
   logic            pv_w, dv_w, out_kind_w;
   logic [2*B-1:0]  dva_w;
   logic [B+DW-1:0] dvb_w;
   logic [DW-1:0]   dsa_w, dsb_w;
   logic [SW-1:0]   ps_w, ds_w;
   logic [B-1:0]    qa_w, qb_w;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   rhc_prep #(.CHANNEL_BITS(CHANNEL_BITS)) u_prep (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .kind(req_kind), .a0(req_chan_first), .a1(req_chan_second),
      .a2(req_chan_third), .alpha(req_alpha_in), .out_valid(pv_w),
      .dividend_a(dva_w), .divisor_a(dsa_w), .dividend_b(dvb_w),
      .divisor_b(dsb_w), .side(ps_w)
   );

   rhc_div #(.CHANNEL_BITS(CHANNEL_BITS), .SW(SW)) u_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(pv_w),
      .dividend_a(dva_w), .divisor_a(dsa_w), .dividend_b(dvb_w),
      .divisor_b(dsb_w), .side_in(ps_w), .out_valid(dv_w),
      .quot_a(qa_w), .quot_b(qb_w), .side_out(ds_w)
   );

   rhc_post #(.CHANNEL_BITS(CHANNEL_BITS)) u_post (
      .clock(clock), .reset(reset), .en(en), .in_valid(dv_w),
      .quot_a(qa_w), .quot_b(qb_w), .side(ds_w), .out_valid(rsp_valid),
      .out_kind(out_kind_w), .out_first(rsp_out_first),
      .out_second(rsp_out_second), .out_third(rsp_out_third),
      .out_alpha(rsp_alpha_out)
   );

   a_ready_follows_output: assert property (@(posedge clock)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output register state");

   a_black_has_no_saturation: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_kind_w == rhc_pkg::KIND_TO_HSV && rsp_out_third == '0)
         |-> (rsp_out_second == '0 && rsp_out_first == '0))
      else $error("black pixel produced nonzero hue or saturation");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      (!en) |=> ($stable(pv_w) && $stable(dv_w)))
      else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

// ===== hdl/rhc_prep.sv =====
// Two front stages: channel extremes and products, then dividends and divisors.
// Depends on rhc_pkg.
`default_nettype none
module rhc_prep #(
   parameter int unsigned CHANNEL_BITS = rhc_pkg::CHAN_BITS,
   localparam int unsigned B  = CHANNEL_BITS,
   localparam int unsigned DW = B + 3,
   localparam int unsigned SW = 1 + B + B + 3 + B
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic          kind,
   input  wire logic [B-1:0]  a0,
   input  wire logic [B-1:0]  a1,
   input  wire logic [B-1:0]  a2,
   input  wire logic [B-1:0]  alpha,
   output logic               out_valid,
   output logic [2*B-1:0]     dividend_a,
   output logic [DW-1:0]      divisor_a,
   output logic [B+DW-1:0]    dividend_b,
   output logic [DW-1:0]      divisor_b,
   output logic [SW-1:0]      side
);
   localparam logic [B-1:0] MAXV = {B{1'b1}};

   logic            vld1_ff, vld2_ff;
   logic            kind1_ff, kind2_ff;
   logic [B-1:0]    r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff, alpha1_ff, alpha2_ff;
   logic [2*B-1:0]  prod1_ff;
   logic [B+2:0]    p1_ff;
   logic [2*B-1:0]  dva_ff;
   logic [B+DW-1:0] dvb_ff;
   logic [DW-1:0]   dsa_ff, dsb_ff;
   logic [B-1:0]    v2_ff, f2_ff;
   logic [2:0]      sec2_ff;

   logic [B-1:0]    mx_in, mn_in;
   logic [B-1:0]    c_w;
   logic [DW-1:0]   c6_w, num_w;
   logic [2*B-1:0]  dva_in;
   logic [B+DW-1:0] dvb_in;
   logic [DW-1:0]   dsa_in, dsb_in;

   always_comb begin
      mx_in = a0;
      mn_in = a0;
      if (a1 > mx_in) mx_in = a1;
      if (a2 > mx_in) mx_in = a2;
      if (a1 < mn_in) mn_in = a1;
      if (a2 < mn_in) mn_in = a2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff  <= kind;
         r1_ff     <= a0;
         g1_ff     <= a1;
         b1_ff     <= a2;
         mx1_ff    <= mx_in;
         mn1_ff    <= mn_in;
         alpha1_ff <= alpha;
         prod1_ff  <= a1 * a2;
         p1_ff     <= {1'b0, a0, 2'b00} + {2'b00, a0, 1'b0};
      end
   end

   always_comb begin
      c_w    = mx1_ff - mn1_ff;
      c6_w   = {1'b0, c_w, 2'b00} + {2'b00, c_w, 1'b0};
      priority if (r1_ff == mx1_ff) begin
         if (g1_ff >= b1_ff) num_w = DW'(g1_ff - b1_ff);
         else                num_w = c6_w - DW'(b1_ff - g1_ff);
      end else if (g1_ff == mx1_ff) begin
         num_w = {2'b00, c_w, 1'b0} + DW'(b1_ff) - DW'(r1_ff);
      end else begin
         num_w = {1'b0, c_w, 2'b00} + DW'(r1_ff) - DW'(g1_ff);
      end
      if (kind1_ff == rhc_pkg::KIND_TO_HSV) begin
         dva_in = {c_w, {B{1'b0}}} - (2*B)'(c_w);
         dsa_in = (mx1_ff == '0) ? DW'(1) : DW'(mx1_ff);
         dvb_in = {num_w, {B{1'b0}}};
         dsb_in = (c_w == '0) ? DW'(1) : c6_w;
      end else begin
         dva_in = prod1_ff;
         dsa_in = DW'(MAXV);
         dvb_in = '0;
         dsb_in = DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind2_ff  <= kind1_ff;
         alpha2_ff <= alpha1_ff;
         dva_ff    <= dva_in;
         dvb_ff    <= dvb_in;
         dsa_ff    <= dsa_in;
         dsb_ff    <= dsb_in;
         v2_ff     <= (kind1_ff == rhc_pkg::KIND_TO_HSV) ? mx1_ff : b1_ff;
         sec2_ff   <= p1_ff[B+2:B];
         f2_ff     <= p1_ff[B-1:0];
      end
   end

   assign out_valid  = vld2_ff;
   assign dividend_a = dva_ff;
   assign divisor_a  = dsa_ff;
   assign dividend_b = dvb_ff;
   assign divisor_b  = dsb_ff;
   assign side       = {kind2_ff, alpha2_ff, v2_ff, sec2_ff, f2_ff};
endmodule
`default_nettype wire

// ===== hdl/rhc_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on rhc_pkg for the default width.
`default_nettype none
module rhc_div #(
   parameter int unsigned CHANNEL_BITS = rhc_pkg::CHAN_BITS,
   parameter int unsigned SW = 1,
   localparam int unsigned B  = CHANNEL_BITS,
   localparam int unsigned DW = B + 3,
   localparam int unsigned RW = B + 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [2*B-1:0]  dividend_a,
   input  wire logic [DW-1:0]   divisor_a,
   input  wire logic [B+DW-1:0] dividend_b,
   input  wire logic [DW-1:0]   divisor_b,
   input  wire logic [SW-1:0]   side_in,
   output logic                 out_valid,
   output logic [B-1:0]         quot_a,
   output logic [B-1:0]         quot_b,
   output logic [SW-1:0]        side_out
);
   logic [RW-1:0] rema_w [0:B];
   logic [RW-1:0] remb_w [0:B];
   logic [B-1:0]  loa_w  [0:B];
   logic [B-1:0]  lob_w  [0:B];
   logic [B-1:0]  qa_w   [0:B];
   logic [B-1:0]  qb_w   [0:B];
   logic [DW-1:0] da_w   [0:B];
   logic [DW-1:0] db_w   [0:B];
   logic [SW-1:0] sd_w   [0:B];
   logic          vld_w  [0:B];

   assign rema_w[0] = RW'(dividend_a[2*B-1:B]);
   assign remb_w[0] = RW'(dividend_b[B+DW-1:B]);
   assign loa_w[0]  = dividend_a[B-1:0];
   assign lob_w[0]  = dividend_b[B-1:0];
   assign qa_w[0]   = '0;
   assign qb_w[0]   = '0;
   assign da_w[0]   = divisor_a;
   assign db_w[0]   = divisor_b;
   assign sd_w[0]   = side_in;
   assign vld_w[0]  = in_valid;

   for (genvar k = 0; k < B; k++) begin : g_step
      logic [RW-1:0] ta_w, tb_w;
      logic          ga_w, gb_w;
      logic [RW-1:0] rema_ff, remb_ff;
      logic [B-1:0]  loa_ff, lob_ff, qa_ff, qb_ff;
      logic [DW-1:0] da_ff, db_ff;
      logic [SW-1:0] sd_ff;
      logic          vld_ff;

      assign ta_w = {rema_w[k][RW-2:0], loa_w[k][B-1]};
      assign tb_w = {remb_w[k][RW-2:0], lob_w[k][B-1]};
      assign ga_w = ta_w >= RW'(da_w[k]);
      assign gb_w = tb_w >= RW'(db_w[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rema_ff <= ga_w ? ta_w - RW'(da_w[k]) : ta_w;
            remb_ff <= gb_w ? tb_w - RW'(db_w[k]) : tb_w;
            loa_ff  <= {loa_w[k][B-2:0], 1'b0};
            lob_ff  <= {lob_w[k][B-2:0], 1'b0};
            qa_ff   <= {qa_w[k][B-2:0], ga_w};
            qb_ff   <= {qb_w[k][B-2:0], gb_w};
            da_ff   <= da_w[k];
            db_ff   <= db_w[k];
            sd_ff   <= sd_w[k];
         end
      end

      assign rema_w[k+1] = rema_ff;
      assign remb_w[k+1] = remb_ff;
      assign loa_w[k+1]  = loa_ff;
      assign lob_w[k+1]  = lob_ff;
      assign qa_w[k+1]   = qa_ff;
      assign qb_w[k+1]   = qb_ff;
      assign da_w[k+1]   = da_ff;
      assign db_w[k+1]   = db_ff;
      assign sd_w[k+1]   = sd_ff;
      assign vld_w[k+1]  = vld_ff;
   end

   assign out_valid = vld_w[B];
   assign quot_a    = qa_w[B];
   assign quot_b    = qb_w[B];
   assign side_out  = sd_w[B];
endmodule
`default_nettype wire

// ===== hdl/rhc_post.sv =====
// Back stages: sector blend product, then channel assembly into the output register.
// Depends on rhc_pkg.
`default_nettype none
module rhc_post #(
   parameter int unsigned CHANNEL_BITS = rhc_pkg::CHAN_BITS,
   localparam int unsigned B  = CHANNEL_BITS,
   localparam int unsigned SW = 1 + B + B + 3 + B
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [B-1:0]  quot_a,
   input  wire logic [B-1:0]  quot_b,
   input  wire logic [SW-1:0] side,
   output logic               out_valid,
   output logic               out_kind,
   output logic [B-1:0]       out_first,
   output logic [B-1:0]       out_second,
   output logic [B-1:0]       out_third,
   output logic [B-1:0]       out_alpha
);
   logic          s_kind_w;
   logic [B-1:0]  s_alpha_w, s_v_w, s_f_w;
   logic [2:0]    s_sec_w;
   logic [B:0]    wt_w;

   logic          vld1_ff, vld2_ff, kind1_ff, kind2_ff;
   logic [B-1:0]  alpha1_ff, v1_ff, c1_ff, h1_ff, m1_ff;
   logic [2:0]    sec1_ff;
   logic [2*B:0]  prod1_ff;
   logic [B-1:0]  o1_ff, o2_ff, o3_ff, alpha2_ff;
   logic [B-1:0]  x_w, rr_w, gg_w, bb_w, o1_in, o2_in, o3_in;

   assign {s_kind_w, s_alpha_w, s_v_w, s_sec_w, s_f_w} = side;
   assign wt_w = s_sec_w[0] ? (((B+1)'(1) << B) - (B+1)'(s_f_w)) : (B+1)'(s_f_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff  <= s_kind_w;
         alpha1_ff <= s_alpha_w;
         v1_ff     <= s_v_w;
         c1_ff     <= quot_a;
         h1_ff     <= quot_b;
         m1_ff     <= s_v_w - quot_a;
         sec1_ff   <= s_sec_w;
         prod1_ff  <= quot_a * wt_w;
      end
   end

   always_comb begin
      x_w  = prod1_ff[2*B-1:B];
      rr_w = '0;
      gg_w = '0;
      bb_w = '0;
      unique case (sec1_ff)
         rhc_pkg::SEC_RED:     begin rr_w = c1_ff; gg_w = x_w;   end
         rhc_pkg::SEC_YELLOW:  begin rr_w = x_w;   gg_w = c1_ff; end
         rhc_pkg::SEC_GREEN:   begin gg_w = c1_ff; bb_w = x_w;   end
         rhc_pkg::SEC_CYAN:    begin gg_w = x_w;   bb_w = c1_ff; end
         rhc_pkg::SEC_BLUE:    begin rr_w = x_w;   bb_w = c1_ff; end
         default:              begin rr_w = c1_ff; bb_w = x_w;   end
      endcase
      if (kind1_ff == rhc_pkg::KIND_TO_HSV) begin
         o1_in = h1_ff;
         o2_in = c1_ff;
         o3_in = v1_ff;
      end else begin
         o1_in = rr_w + m1_ff;
         o2_in = gg_w + m1_ff;
         o3_in = bb_w + m1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind2_ff  <= kind1_ff;
         alpha2_ff <= alpha1_ff;
         o1_ff     <= o1_in;
         o2_ff     <= o2_in;
         o3_ff     <= o3_in;
      end
   end

   assign out_valid  = vld2_ff;
   assign out_kind   = kind2_ff;
   assign out_first  = o1_ff;
   assign out_second = o2_ff;
   assign out_third  = o3_ff;
   assign out_alpha  = alpha2_ff;
endmodule
`default_nettype wire

// ===== sim/rhc_checker.sv =====
// Checker for the RGB/HSV converter: watches both channels and predicts each pixel.
// Depends on rhc_pkg for the kind codes; hands its failure count to the testbench top.
`timescale 1ns / 100ps
`default_nettype none
module rhc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_kind,
   input  wire logic [11:0] req_chan_first,
   input  wire logic [11:0] req_chan_second,
   input  wire logic [11:0] req_chan_third,
   input  wire logic [11:0] req_alpha_in,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [11:0] rsp_out_first,
   input  wire logic [11:0] rsp_out_second,
   input  wire logic [11:0] rsp_out_third,
   input  wire logic [11:0] rsp_alpha_out,
   output int               fail_count,
   output int               pending_count,
   output int               pixels_checked
);
   typedef struct packed {
      logic [11:0] first;
      logic [11:0] second;
      logic [11:0] third;
      logic [11:0] alpha;
   } pixel_type;

   pixel_type expected_pixels[$];

   function automatic pixel_type convert_pixel(logic kind, logic [11:0] a, logic [11:0] b,
                                               logic [11:0] c, logic [11:0] al);
      pixel_type px;
      longint unsigned mx, mn, sp, num, p, sec, f, ch, x, m, rr, gg, bb;
      px.alpha = al;
      if (kind == rhc_pkg::KIND_TO_HSV) begin
         mx = a; mn = a;
         if (b > mx) mx = b;
         if (c > mx) mx = c;
         if (b < mn) mn = b;
         if (c < mn) mn = c;
         sp = mx - mn;
         px.third = mx[11:0];
         px.first = '0;
         px.second = '0;
         if (mx != 0 && sp != 0) begin
            px.second = 12'((sp * 4095) / mx);
            if (a == mx) num = (b >= c) ? (b - c) : (6 * sp - (c - b));
            else if (b == mx) num = 2 * sp + c - a;
            else num = 4 * sp + a - b;
            px.first = 12'((num * 4096) / (6 * sp));
         end
      end else begin
         p = a * 6;
         sec = p >> 12;
         f = p & 4095;
         ch = (b * c) / 4095;
         x = sec[0] ? (ch * (4096 - f)) >> 12 : (ch * f) >> 12;
         rr = 0; gg = 0; bb = 0;
         case (sec)
            0: begin rr = ch; gg = x; end
            1: begin rr = x; gg = ch; end
            2: begin gg = ch; bb = x; end
            3: begin gg = x; bb = ch; end
            4: begin rr = x; bb = ch; end
            default: begin rr = ch; bb = x; end
         endcase
         m = c - ch;
         px.first = 12'(rr + m);
         px.second = 12'(gg + m);
         px.third = 12'(bb + m);
      end
      return px;
   endfunction

   assign pending_count = expected_pixels.size();

   always @(posedge clock) begin
      pixel_type want, got;
      if (reset) begin
         fail_count <= 0;
         pixels_checked <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(convert_pixel(req_kind, req_chan_first, req_chan_second,
                                                    req_chan_third, req_alpha_in));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_first, rsp_out_second, rsp_out_third, rsp_alpha_out};
            pixels_checked <= pixels_checked + 1;
            if (expected_pixels.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected rsp beat %h", got);
            end else begin
               want = expected_pixels.pop_front();
               if (want != got) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                              want.first, want.second, want.third, want.alpha,
                              got.first, got.second, got.third, got.alpha);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== sim/tb_rgb_hsv_convert.sv =====
// Testbench top for rgb_hsv_convert: directed and random pixels in both directions.
// Depends on rhc_pkg, the converter RTL and rhc_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_rgb_hsv_convert;
   localparam int LATENCY = 16;
   localparam int WATCHDOG = 5000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_kind = 0;
   logic [11:0] req_chan_first = 0, req_chan_second = 0, req_chan_third = 0, req_alpha_in = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [11:0] rsp_out_first, rsp_out_second, rsp_out_third, rsp_alpha_out;
   int fail_count, pending_count, pixels_checked;
   int idle_cycles = 0;
   bit calm = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   rgb_hsv_convert dut (.*);
   rhc_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 38);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("tb_rgb_hsv_convert NOT OK");
         $finish;
      end
   end

   task automatic send_pixel(logic kind, logic [11:0] a, logic [11:0] b, logic [11:0] c,
                             logic [11:0] al);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_chan_first <= a;
      req_chan_second <= b;
      req_chan_third <= c;
      req_alpha_in <= al;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [11:0] pick_chan();
      case ($urandom_range(5))
         0: return 12'd0;
         1: return 12'hfff;
         default: return 12'($urandom);
      endcase
   endfunction

   initial begin
      logic [11:0] g;
      repeat (12) @(posedge clock);
      reset <= 0;
      send_pixel(rhc_pkg::KIND_TO_HSV, 0, 0, 0, 0);
      send_pixel(rhc_pkg::KIND_TO_HSV, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_pixel(rhc_pkg::KIND_TO_HSV, 2000, 2000, 2000, 5);
      send_pixel(rhc_pkg::KIND_TO_HSV, 12'hfff, 0, 0, 1);
      send_pixel(rhc_pkg::KIND_TO_HSV, 0, 12'hfff, 0, 2);
      send_pixel(rhc_pkg::KIND_TO_HSV, 0, 0, 12'hfff, 3);
      send_pixel(rhc_pkg::KIND_TO_HSV, 12'hfff, 0, 1, 4);
      send_pixel(rhc_pkg::KIND_TO_HSV, 12'hfff, 12'hfff, 0, 6);
      send_pixel(rhc_pkg::KIND_TO_HSV, 0, 12'hfff, 12'hfff, 7);
      send_pixel(rhc_pkg::KIND_TO_HSV, 100, 50, 100, 8);
      send_pixel(rhc_pkg::KIND_TO_RGB, 0, 12'hfff, 12'hfff, 9);
      send_pixel(rhc_pkg::KIND_TO_RGB, 0, 0, 12'hfff, 10);
      send_pixel(rhc_pkg::KIND_TO_RGB, 12'hfff, 12'hfff, 12'hfff, 11);
      send_pixel(rhc_pkg::KIND_TO_RGB, 12'hfff, 12'hfff, 0, 12);
      for (int s = 1; s < 6; s++)
         send_pixel(rhc_pkg::KIND_TO_RGB, 12'((s * 4096 + 5) / 6), 12'hfff, 3000, 12'(s));
      send_pixel(rhc_pkg::KIND_TO_RGB, 682, 12'hfff, 12'hfff, 12'hfff);
      send_pixel(rhc_pkg::KIND_TO_RGB, 683, 1, 1, 0);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 450; i++) begin
         calm = (i >= 150 && i < 230);
         if (i == 300) begin
            req_valid <= 0;
            while (pending_count != 0) @(posedge clock);
         end
         if ($urandom_range(9) == 0) begin
            g = pick_chan();
            send_pixel(rhc_pkg::KIND_TO_HSV, g, g, g, 12'($urandom));
         end else
            send_pixel(1'($urandom), pick_chan(), pick_chan(), pick_chan(), 12'($urandom));
      end
      req_valid <= 0;
      calm = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      $display("Ran directed corner pixels and 450 random pixels in both directions,");
      $display("%0d results checked under random stalls on both sides.", pixels_checked);
      if (fail_count == 0 && pending_count == 0) $display("tb_rgb_hsv_convert OK");
      else $display("tb_rgb_hsv_convert NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/rhc_pkg.sv
hdl/rhc_prep.sv
hdl/rhc_div.sv
hdl/rhc_post.sv
hdl/rgb_hsv_convert.sv
sim/rhc_checker.sv
sim/tb_rgb_hsv_convert.sv
